/* rtl/qbrf_pkg.sv */
// Shared types and constants for the quartic bisection root finder.
// Used by qbrf_horner and quartic_bisection_root_finder; depends on nothing.
package qbrf_pkg;

  // Default build values.
  localparam int MAX_STEPS_DEF     = 48;
  localparam int FRACTION_BITS_DEF = 16;

  // Fixed field widths.
  localparam int X_W      = 32;  // Q-format operand and interval ends
  localparam int COEF_W   = 16;  // integer coefficients
  localparam int TOL_W    = 31;  // tolerance and half width
  localparam int STEP_W   = 6;   // step counter
  localparam int ACC_W    = 64;  // Horner accumulator
  localparam int MAG_W    = 62;  // accumulator magnitude
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Symmetric saturation bound of the accumulator: 2^62 - 1.
  localparam logic [ACC_W-1:0] ACC_LIM = {2'b00, {MAG_W{1'b1}}};

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(66);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_X4 = 3'd0,
    CFG_COEF_X3 = 3'd1,
    CFG_COEF_X2 = 3'd2,
    CFG_COEF_X1 = 3'd3,
    CFG_COEF_X0 = 3'd4,
    CFG_TOL     = 3'd5
  } cfg_idx_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_ROOT    = 2'd0,
    STAT_EMPTY   = 2'd1,
    STAT_NO_SIGN = 2'd2,
    STAT_LIMIT   = 2'd3
  } status_t;

  // The five polynomial coefficients, highest power first.
  typedef struct packed {
    logic [COEF_W-1:0] x4;
    logic [COEF_W-1:0] x3;
    logic [COEF_W-1:0] x2;
    logic [COEF_W-1:0] x1;
    logic [COEF_W-1:0] x0;
  } coef_set_t;

  // Horner evaluator sequencer states.
  typedef enum logic [2:0] {
    EV_IDLE,
    EV_ABS,
    EV_MUL_LO,
    EV_MUL_HI,
    EV_SCALE,
    EV_ACC
  } ev_state_t;

  // Top-level search sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL_LO,
    ST_EVAL_HI,
    ST_SPLIT,
    ST_EVAL_MID,
    ST_CHECK,
    ST_DONE
  } st_state_t;

endpackage

/* rtl/qbrf_horner.sv */
// Fixed-point quartic evaluator by Horner's rule on one shared 32x32 multiplier.
// Depends on qbrf_pkg. The operand x must stay stable from start to done.
module qbrf_horner
  import qbrf_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [X_W-1:0]   x,
  input  coef_set_t               coefs,
  output logic signed [ACC_W-1:0] f,
  output logic                    done
);

  localparam int SAT_LSB = 30 + FRACTION_BITS;
  localparam int HI_SHL  = 32 - FRACTION_BITS;

  ev_state_t state, state_next;

  logic signed [ACC_W-1:0] acc;
  logic [MAG_W-1:0]        ma;
  logic [X_W-1:0]          mx;
  logic                    neg;
  logic [63:0]             plo;
  logic [MAG_W-1:0]        phi;
  logic [ACC_W-1:0]        mag;
  logic [1:0]              term;

  logic [X_W-1:0]          mul_a;
  logic [63:0]             mul_p;
  logic [ACC_W-1:0]        acc_abs;
  logic [X_W:0]            x_abs;
  logic [ACC_W-1:0]        m_raw;
  logic                    m_sat;
  logic [COEF_W-1:0]       coef_sel;
  logic signed [ACC_W-1:0] c4_scaled;
  logic signed [ACC_W-1:0] c_scaled;
  logic signed [ACC_W-1:0] m_signed;
  logic signed [ACC_W-1:0] sum;
  logic signed [ACC_W-1:0] sum_clamped;

  // Shared multiplier: low then high half of the accumulator magnitude.
  assign mul_a = (state == EV_MUL_LO) ? ma[X_W-1:0] : {2'b00, ma[MAG_W-1:X_W]};
  assign mul_p = mul_a * mx;

  // Magnitudes of the accumulator and of the operand.
  assign acc_abs = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
  assign x_abs   = x[X_W-1] ? (X_W+1)'(-{x[X_W-1], x}) : {1'b0, x};

  // Product magnitude shifted down by the fraction bits, with saturation.
  assign m_sat = |phi[MAG_W-1:SAT_LSB];
  assign m_raw = ({2'b00, phi} << HI_SHL) + (plo >> FRACTION_BITS);

  // Coefficient for the current Horner term, scaled to the fixed-point grid.
  always_comb begin
    case (term)
      2'd0:    coef_sel = coefs.x3;
      2'd1:    coef_sel = coefs.x2;
      2'd2:    coef_sel = coefs.x1;
      default: coef_sel = coefs.x0;
    endcase
  end

  assign c4_scaled = $signed({{(ACC_W-COEF_W){coefs.x4[COEF_W-1]}}, coefs.x4}) <<<
                     FRACTION_BITS;
  assign c_scaled  = $signed({{(ACC_W-COEF_W){coef_sel[COEF_W-1]}}, coef_sel}) <<<
                     FRACTION_BITS;

  // Apply the product sign, add the coefficient and clamp symmetrically.
  assign m_signed = neg ? -$signed(mag) : $signed(mag);
  assign sum      = m_signed + c_scaled;

  always_comb begin
    if (sum > $signed(ACC_LIM)) begin
      sum_clamped = $signed(ACC_LIM);
    end else if (sum < -$signed(ACC_LIM)) begin
      sum_clamped = -$signed(ACC_LIM);
    end else begin
      sum_clamped = sum;
    end
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    unique case (state)
      EV_IDLE:   if (start) state_next = EV_ABS;
      EV_ABS:    state_next = EV_MUL_LO;
      EV_MUL_LO: state_next = EV_MUL_HI;
      EV_MUL_HI: state_next = EV_SCALE;
      EV_SCALE:  state_next = EV_ACC;
      EV_ACC:    state_next = (term == 2'd3) ? EV_IDLE : EV_ABS;
      default:   state_next = EV_IDLE;
    endcase
  end

  // State register and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= EV_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == EV_ACC) && (term == 2'd3);
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      EV_IDLE: begin
        acc  <= c4_scaled;
        term <= 2'd0;
      end
      EV_ABS: begin
        ma  <= acc_abs[MAG_W-1:0];
        mx  <= x_abs[X_W-1:0];
        neg <= acc[ACC_W-1] ^ x[X_W-1];
      end
      EV_MUL_LO: plo <= mul_p;
      EV_MUL_HI: phi <= mul_p[MAG_W-1:0];
      EV_SCALE: begin
        mag <= (m_sat || (m_raw > ACC_LIM)) ? ACC_LIM : m_raw;
      end
      EV_ACC: begin
        acc  <= sum_clamped;
        term <= term + 2'd1;
      end
      default: ;
    endcase
  end

  assign f = acc;

endmodule

/* rtl/quartic_bisection_root_finder.sv */
// Quartic bisection root finder: one item in, one result item out.
// An empty interval skips the evaluations, and a rejected sign test stops after
// the two end evaluations. Each polynomial evaluation runs on the single shared
// multiplier.
// One item at a time; the input stalls until its result is in the output register.
// Reset (synchronous, rst high) clears control, coefficients to 0, tolerance to 66.
module quartic_bisection_root_finder
  import qbrf_pkg::*;
#(
  parameter int MAX_STEPS     = MAX_STEPS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // Input item channel.
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [X_W-1:0] interval_low,
  input  logic signed [X_W-1:0] interval_high,
  // Result item channel.
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [X_W-1:0] root,
  output logic [TOL_W-1:0]      half_width,
  output logic [STEP_W-1:0]     steps_taken,
  output logic [1:0]            status,
  // Configuration write channel.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  st_state_t state, state_next;

  coef_set_t           coefs;
  logic [TOL_W-1:0]    tolerance;

  logic signed [X_W-1:0]   bracket_low;
  logic signed [X_W-1:0]   bracket_high;
  logic signed [X_W-1:0]   midpoint;
  logic [STEP_W-1:0]       step_count;
  logic signed [ACC_W-1:0] f_low;
  logic signed [ACC_W-1:0] f_mid;
  status_t                 res_status;
  logic signed [X_W-1:0]   eval_x;
  logic                    ev_start;

  logic signed [ACC_W-1:0] ev_f;
  logic                    ev_done;

  logic                    in_take;
  logic                    out_free;
  logic [X_W:0]            span;
  logic signed [X_W-1:0]   mid_calc;
  logic signed [ACC_W-1:0] tol_ext;
  logic                    within_tol;
  logic                    same_sign;
  logic                    go_left;
  logic                    at_limit;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // Bracket width and midpoint; high never falls below low here, so the span is never negative.
  assign span     = {bracket_high[X_W-1], bracket_high} - {bracket_low[X_W-1], bracket_low};
  assign mid_calc = bracket_low + $signed(span[X_W:1]);

  // Stop test and bracket decision.
  assign tol_ext    = $signed({{(ACC_W-TOL_W){1'b0}}, tolerance});
  assign within_tol = (f_mid <= tol_ext) && (f_mid >= -tol_ext);
  assign same_sign  = (!f_low[ACC_W-1] && (|f_low) && !ev_f[ACC_W-1] && (|ev_f)) ||
                      (f_low[ACC_W-1] && ev_f[ACC_W-1]);
  assign go_left    = (f_low[ACC_W-1] && !f_mid[ACC_W-1] && (|f_mid)) ||
                      (!f_low[ACC_W-1] && (|f_low) && f_mid[ACC_W-1]);
  assign at_limit   = (step_count >= STEP_W'(MAX_STEPS));

  // Shared polynomial evaluator.
  qbrf_horner #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_horner (
    .clk   (clk),
    .rst   (rst),
    .start (ev_start),
    .x     (eval_x),
    .coefs (coefs),
    .f     (ev_f),
    .done  (ev_done)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      coefs     <= '0;
      tolerance <= TOL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_COEF_X4: coefs.x4  <= cfg_data[COEF_W-1:0];
        CFG_COEF_X3: coefs.x3  <= cfg_data[COEF_W-1:0];
        CFG_COEF_X2: coefs.x2  <= cfg_data[COEF_W-1:0];
        CFG_COEF_X1: coefs.x1  <= cfg_data[COEF_W-1:0];
        CFG_COEF_X0: coefs.x0  <= cfg_data[COEF_W-1:0];
        CFG_TOL:     tolerance <= cfg_data[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // Search sequencer next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_take) begin
          state_next = (interval_low >= interval_high) ? ST_DONE : ST_EVAL_LO;
        end
      end
      ST_EVAL_LO:  if (ev_done) state_next = ST_EVAL_HI;
      ST_EVAL_HI:  if (ev_done) state_next = same_sign ? ST_DONE : ST_SPLIT;
      ST_SPLIT:    state_next = ST_EVAL_MID;
      ST_EVAL_MID: if (ev_done) state_next = ST_CHECK;
      ST_CHECK:    state_next = (within_tol || at_limit) ? ST_DONE : ST_SPLIT;
      ST_DONE:     if (out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ev_start  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      ev_start <= (state == ST_IDLE && in_take && (interval_low < interval_high)) ||
                  (state == ST_EVAL_LO && ev_done) ||
                  (state == ST_SPLIT);
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Search datapath.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_take) begin
          bracket_low  <= interval_low;
          bracket_high <= interval_high;
          eval_x       <= interval_low;
          step_count   <= '0;
          res_status   <= STAT_EMPTY;
        end
      end
      ST_EVAL_LO: begin
        if (ev_done) begin
          f_low  <= ev_f;
          eval_x <= bracket_high;
        end
      end
      ST_EVAL_HI: begin
        if (ev_done) begin
          res_status <= same_sign ? STAT_NO_SIGN : STAT_ROOT;
        end
      end
      ST_SPLIT: begin
        midpoint <= mid_calc;
        eval_x   <= mid_calc;
      end
      ST_EVAL_MID: begin
        if (ev_done) begin
          f_mid <= ev_f;
        end
      end
      ST_CHECK: begin
        if (within_tol) begin
          res_status <= STAT_ROOT;
        end else if (at_limit) begin
          res_status <= STAT_LIMIT;
        end else begin
          if (go_left) begin
            bracket_high <= midpoint;
          end else begin
            bracket_low <= midpoint;
            f_low       <= f_mid;
          end
          step_count <= step_count + STEP_W'(1);
        end
      end
      default: ;
    endcase
  end

  // Output register; a rejected interval reports zeros.
  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      status <= res_status;
      if (res_status == STAT_EMPTY || res_status == STAT_NO_SIGN) begin
        root        <= '0;
        half_width  <= '0;
        steps_taken <= '0;
      end else begin
        root        <= midpoint;
        half_width  <= span[TOL_W:1];
        steps_taken <= step_count;
      end
    end
  end

endmodule
